// ----- hdl/kdeq_pkg.sv -----
// Shared types, codes and constants of the key debounce event queue.
package kdeq_pkg;

  // Input kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  // Configuration register indexes
  localparam logic CFG_LONG_PRESS = 1'b0;
  localparam logic CFG_REPEAT     = 1'b1;

  // Field widths
  localparam int LEVEL_W = 4;
  localparam int KEY_W   = 3;
  localparam int TYPE_W  = 2;
  localparam int EV_W    = KEY_W + TYPE_W;
  localparam int CNT_W   = 16;
  localparam int REP_W   = 8;
  localparam int CFG_W   = 16;

  // Reset values and limits
  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd80;
  localparam logic [REP_W-1:0] REPEAT_RESET     = 8'd10;
  localparam logic [CNT_W-1:0] PRESS_MAX        = 16'hFFFF;

  typedef enum logic [1:0] {
    DB_REL_STABLE   = 2'd0,
    DB_PRESS_DEB    = 2'd1,
    DB_PRESS_STABLE = 2'd2,
    DB_REL_DEB      = 2'd3
  } db_state_t;

  typedef enum logic [TYPE_W-1:0] {
    EV_SHORT  = 2'd0,
    EV_LONG   = 2'd1,
    EV_REPEAT = 2'd2
  } ev_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_REP,
    ST_OUT
  } seq_state_t;

  // Event pushed into the ring
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    ev_type_t         etype;
  } push_t;

  // Outcome of one key step in the shared counter unit
  typedef struct packed {
    logic     ev_valid;
    ev_type_t ev_type;
    logic     rep;
  } key_res_t;

  // Two-tick debounce machine; level 0 means pressed
  function automatic db_state_t db_next(db_state_t st, logic level);
    db_state_t nx;
    unique case (st)
      DB_REL_STABLE:   nx = level ? DB_REL_STABLE : DB_PRESS_DEB;
      DB_PRESS_DEB:    nx = level ? DB_REL_STABLE : DB_PRESS_STABLE;
      DB_PRESS_STABLE: nx = level ? DB_REL_DEB    : DB_PRESS_STABLE;
      DB_REL_DEB:      nx = level ? DB_REL_STABLE : DB_PRESS_STABLE;
      default:         nx = DB_REL_STABLE;
    endcase
    return nx;
  endfunction

endpackage

// ----- hdl/kdeq_key_unit.sv -----
// Per-key debounce state and counters with one shared increment/compare unit.
module kdeq_key_unit #(
  parameter int NUM_KEYS = 4,
  localparam int IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick_load,
  input  logic [kdeq_pkg::LEVEL_W-1:0]   key_levels,
  input  logic                           step,
  input  logic [IW-1:0]                  idx,
  input  logic [kdeq_pkg::CNT_W-1:0]     long_press_ticks,
  input  logic [kdeq_pkg::REP_W-1:0]     repeat_interval,
  output kdeq_pkg::key_res_t             res
);
  import kdeq_pkg::*;

  db_state_t        db_st      [NUM_KEYS];
  logic [CNT_W-1:0] press_cnt  [NUM_KEYS];
  logic [REP_W-1:0] rep_cnt    [NUM_KEYS];
  logic             long_fired [NUM_KEYS];

  // Keys beyond the level input read as pressed
  logic [NUM_KEYS+LEVEL_W-1:0] lv_ext;
  assign lv_ext = {{NUM_KEYS{1'b0}}, key_levels};

  logic             pressed;
  logic [CNT_W-1:0] pc, pc_inc, press_cnt_next;
  logic [REP_W-1:0] rc_base, rc_inc, rep_cnt_next;
  logic             lf, fire_long, long_fired_next, rep_hit;

  // Shared unit: works on the counters of the selected key
  always_comb begin
    pressed         = (db_st[idx] == DB_PRESS_STABLE);
    pc              = press_cnt[idx];
    lf              = long_fired[idx];
    pc_inc          = (pc == PRESS_MAX) ? pc : pc + 1'b1;
    fire_long       = !lf && (pc_inc >= long_press_ticks);
    rc_base         = fire_long ? '0 : rep_cnt[idx];
    rc_inc          = rc_base + 1'b1;
    rep_hit         = 1'b0;
    press_cnt_next  = '0;
    rep_cnt_next    = '0;
    long_fired_next = 1'b0;
    res             = '{ev_valid: 1'b0, ev_type: EV_SHORT, rep: 1'b0};
    if (pressed) begin
      press_cnt_next  = pc_inc;
      long_fired_next = lf | fire_long;
      rep_cnt_next    = rc_base;
      if (lf | fire_long) begin
        rep_hit      = (rc_inc >= repeat_interval);
        rep_cnt_next = rep_hit ? '0 : rc_inc;
      end
      res.ev_valid = fire_long;
      res.ev_type  = EV_LONG;
      res.rep      = rep_hit;
    end else begin
      res.ev_valid = (pc != '0) && !lf;
      res.ev_type  = EV_SHORT;
    end
  end

  // Debounce all keys on a tick; update one key per step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        db_st[k]      <= DB_REL_STABLE;
        press_cnt[k]  <= '0;
        rep_cnt[k]    <= '0;
        long_fired[k] <= 1'b0;
      end
    end else begin
      if (tick_load) begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          db_st[k] <= db_next(db_st[k], lv_ext[k]);
        end
      end
      if (step) begin
        press_cnt[idx]  <= press_cnt_next;
        rep_cnt[idx]    <= rep_cnt_next;
        long_fired[idx] <= long_fired_next;
      end
    end
  end

endmodule

// ----- hdl/kdeq_queue.sv -----
// Event ring: holds DEPTH-1 events, drops pushes when full, registered read.
module kdeq_queue #(
  parameter int DEPTH = 8,
  localparam int PW = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kdeq_pkg::push_t               push,
  input  logic                          pop,
  output logic [kdeq_pkg::EV_W-1:0]     rd_data,
  output logic                          empty
);
  import kdeq_pkg::*;

  logic [EV_W-1:0] mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr, wr_inc, rd_inc;
  logic            full;

  assign wr_inc = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_inc = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign full   = (wr_inc == rd_ptr);
  assign empty  = (wr_ptr == rd_ptr);

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push.valid && !full) wr_ptr <= wr_inc;
      if (pop && !empty)       rd_ptr <= rd_inc;
    end
  end

  // Storage, write and registered read of the head slot
  always_ff @(posedge clk) begin
    if (push.valid && !full) mem[wr_ptr] <= {push.key, push.etype};
    rd_data <= mem[rd_ptr];
  end

endmodule

// ----- hdl/key_debounce_event_queue.sv -----
// Top level: sequencer, configuration registers and output register.
// Debounce, long-press and repeat detection for NUM_KEYS active-low keys,
// with events kept in a QUEUE_DEPTH-slot ring (QUEUE_DEPTH-1 usable).
// Input channel (in_valid/in_stall): kind 0 is a scan tick carrying
// key_levels, kind 1 polls one event. Output channel (out_valid/out_stall)
// gives one transaction per poll: event_valid, event_key, event_type, all
// zero when the ring was empty. Ticks give no output.
// A tick is debounced for all keys at once, then a single shared counter
// and compare unit steps through the keys, one key per cycle, with an extra
// ST_REP step for a key that queues both a long and a repeat event; in_stall
// stays high until the last key is done.
// A poll reads the ring head through a registered port; the sequencer waits
// in ST_OUT, with in_stall high, while an earlier result is still held by
// out_stall, then loads the result into the output register.
// Configuration (cfg_we/cfg_index/cfg_wdata) is to be written while idle;
// the user keeps to this, the block does not enforce it.
// Synchronous reset clears key state, ring pointers and output valid and
// loads long_press_ticks = 80, repeat_interval = 10; no clearing pass.
module key_debounce_event_queue #(
  parameter int NUM_KEYS    = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [kdeq_pkg::LEVEL_W-1:0]  key_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          event_valid,
  output logic [kdeq_pkg::KEY_W-1:0]    event_key,
  output logic [kdeq_pkg::TYPE_W-1:0]   event_type,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [kdeq_pkg::CFG_W-1:0]    cfg_wdata
);
  import kdeq_pkg::*;

  localparam int IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  seq_state_t       state, state_next;
  logic [IW-1:0]    idx, idx_next;
  logic [CNT_W-1:0] long_press_ticks;
  logic [REP_W-1:0] repeat_interval;
  logic             poll_empty;
  logic             accept, out_free, tick_load, step, pop, out_load, last_key;
  logic [KEY_W-1:0] key_num;
  push_t            push;
  key_res_t         res;
  logic [EV_W-1:0]  rd_data;
  logic             empty;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign tick_load = accept && (kind == KIND_TICK);
  assign last_key  = (idx == IW'(NUM_KEYS - 1));
  assign key_num   = KEY_W'(idx) + 1'b1;

  kdeq_key_unit #(.NUM_KEYS(NUM_KEYS)) u_keys (
    .clk              (clk),
    .rst              (rst),
    .tick_load        (tick_load),
    .key_levels       (key_levels),
    .step             (step),
    .idx              (idx),
    .long_press_ticks (long_press_ticks),
    .repeat_interval  (repeat_interval),
    .res              (res)
  );

  kdeq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (pop),
    .rd_data (rd_data),
    .empty   (empty)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RESET;
      repeat_interval  <= REPEAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS: long_press_ticks <= cfg_wdata;
        CFG_REPEAT:     repeat_interval  <= cfg_wdata[REP_W-1:0];
        default:        ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next = state;
    idx_next   = idx;
    step       = 1'b0;
    pop        = 1'b0;
    out_load   = 1'b0;
    push       = '{valid: 1'b0, key: key_num, etype: EV_SHORT};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          idx_next   = '0;
          state_next = (kind == KIND_TICK) ? ST_KEY : ST_OUT;
        end
      end
      ST_KEY: begin
        step       = 1'b1;
        push.valid = res.ev_valid || res.rep;
        push.etype = res.ev_valid ? res.ev_type : EV_REPEAT;
        if (res.ev_valid && res.rep) begin
          state_next = ST_REP;
        end else if (last_key) begin
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_REP: begin
        push.valid = 1'b1;
        push.etype = EV_REPEAT;
        if (last_key) begin
          state_next = ST_IDLE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_KEY;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          pop        = !poll_empty;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Ring state seen by the poll
  always_ff @(posedge clk) begin
    if (accept) poll_empty <= empty;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_valid <= !poll_empty;
      event_key   <= poll_empty ? '0 : rd_data[EV_W-1:TYPE_W];
      event_type  <= poll_empty ? '0 : rd_data[TYPE_W-1:0];
    end
  end

endmodule

// ----- hdl/kdeq_checker.sv -----
// Port-level checks of the key debounce event queue, bound to the top level.
module kdeq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       event_valid,
  input logic [2:0] event_key,
  input logic [1:0] event_type
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_valid) &&
      $stable(event_key) && $stable(event_type))
    else $error("stalled result changed");

  // Empty poll reports all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> event_key == 3'd0 && event_type == 2'd0)
    else $error("empty poll with nonzero fields");

  // Event type is never the unused code
  a_type_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_valid |-> event_type != 2'd3)
    else $error("illegal event type");

  // Every accepted transaction raises in_stall, so input is not taken back to back
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

endmodule

bind key_debounce_event_queue kdeq_checker u_kdeq_checker (.*);
